FILE: rtl/tcce_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tcce_pkg;

    // input field widths
    localparam int ACTION_W = 2;
    localparam int CHAR_W   = 8;
    localparam int INDEX_W  = 11;
    localparam int ATTR_W   = 8;
    localparam int CELL_W   = CHAR_W + ATTR_W;

    // stream payload widths, padded to whole bytes
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 32;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

    // request kinds
    localparam logic [ACTION_W-1:0] ACT_PUT   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_NONE  = 2'd3;

    // control characters
    localparam logic [CHAR_W-1:0] CHR_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CHR_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CHR_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CHR_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CHR_SPACE = 8'h20;

    localparam int TAB_STEP = 8;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_RDWAIT,
        ST_SCROLL,
        ST_ZERO,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/tcce_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tcce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/text_console_cursor_engine.sv
`timescale 1ns / 1ps
`default_nettype none

// text console cursor engine
// keeps a ROWS x COLUMNS store of 16-bit cells (char low, attribute high)
// and a cursor. requests arrive on the s_ stream with the action on s_tuser:
// put character, read cell, clear screen. each request gives exactly one
// result on the m_ stream with the cursor cell index, the read cell (zero
// unless a read) and a scroll flag.
// cfg_wen / cfg_wdata load the attribute byte used for printable characters;
// write it only while no request is in flight.
// a put character without scroll, the unused action and a read past the store
// pass from the execute state to the done state, which loads the output
// register; a read passes the read-wait state in between. a scroll walks the
// store once through the single ram port pair, moving each row up, then zeroes
// the bottom row; a clear zeroes every cell, one per cycle.
// one request at a time: s_tready stays low until the result has left the
// output register, so a stalled receiver holds off the next request.
// reset: attribute 0x0f, cursor home, then a clearing pass writes zero cells
// before the first request; cfg writes still land.

module text_console_cursor_engine #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // config
    input  wire logic                             cfg_wen,
    input  wire logic [tcce_pkg::ATTR_W-1:0]      cfg_wdata,   // text_attribute
    // request stream
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // char_code [7:0], cell_index [18:8], zero [23:19]
    input  wire logic [tcce_pkg::S_DATA_W-1:0]    s_tdata,
    // action [1:0]
    input  wire logic [tcce_pkg::ACTION_W-1:0]    s_tuser,
    // result stream
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // cursor_position [10:0], cell_char [18:11], cell_attribute [26:19],
    // scrolled [27], zero [31:28]
    output logic [tcce_pkg::M_DATA_W-1:0]         m_tdata
);

    import tcce_pkg::*;

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int MOVE_COUNT = CELL_COUNT - COLUMNS;

    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELL_COUNT - 1);
    localparam logic [ADDR_W-1:0] MOVE_END  = ADDR_W'(MOVE_COUNT);
    localparam logic [ADDR_W-1:0] ROW_SPAN  = ADDR_W'(COLUMNS);

    // control state
    state_t              st_reg, st_next;
    logic [ADDR_W-1:0]   cnt_reg, cnt_next;          // sweep counter
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [ATTR_W-1:0]   attr_reg;
    logic                out_valid_reg, out_valid_next;

    // captured request and result payload
    logic [ACTION_W-1:0] act_reg, act_next;
    logic [CHAR_W-1:0]   code_reg, code_next;
    logic [INDEX_W-1:0]  cidx_reg, cidx_next;
    logic                scr_reg, scr_next;
    logic [CHAR_W-1:0]   rchar_reg, rchar_next;
    logic [ATTR_W-1:0]   rattr_reg, rattr_next;
    logic [INDEX_W-1:0]  opos_reg, opos_next;
    logic [CHAR_W-1:0]   ochar_reg, ochar_next;
    logic [ATTR_W-1:0]   oattr_reg, oattr_next;
    logic                oscr_reg, oscr_next;

    // ram ports
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [CELL_W-1:0]   ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [CELL_W-1:0]   ram_rdata;

    // cursor cell index
    logic [ADDR_W-1:0]   cur_addr;

    // put character decode
    logic [COL_W:0]      put_col;
    logic [ROW_W:0]      put_row;
    logic                put_write;
    logic                put_scroll;
    logic [COL_W-1:0]    put_col_fin;
    logic [ROW_W-1:0]    put_row_fin;

    logic                s_fire;
    logic                cidx_in_range;

    assign s_tready = (st_reg == ST_IDLE) && !out_valid_reg;
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, oscr_reg, oattr_reg, ochar_reg, opos_reg};

    assign cur_addr      = ADDR_W'(row_reg) * ROW_SPAN + ADDR_W'(col_reg);
    assign cidx_in_range = 32'(cidx_reg) < 32'(CELL_COUNT);

    tcce_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_screen (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // cursor movement for one character, with wrap and scroll detection
    always_comb begin
        put_col   = {1'b0, col_reg};
        put_row   = {1'b0, row_reg};
        put_write = 1'b0;
        priority if (code_reg == CHR_BS) begin
            if (col_reg != '0) begin
                put_col = {1'b0, col_reg} - (COL_W+1)'(1);
            end
        end else if (code_reg == CHR_TAB) begin
            put_col = ({1'b0, col_reg} + (COL_W+1)'(TAB_STEP))
                      & ~(COL_W+1)'(TAB_STEP - 1);
        end else if (code_reg == CHR_CR) begin
            put_col = '0;
        end else if (code_reg == CHR_LF) begin
            put_col = '0;
            put_row = {1'b0, row_reg} + (ROW_W+1)'(1);
        end else if (code_reg >= CHR_SPACE) begin
            put_write = 1'b1;
            put_col   = {1'b0, col_reg} + (COL_W+1)'(1);
        end else begin
            put_col = {1'b0, col_reg};
        end
        // line end wraps
        if (32'(put_col) >= 32'(COLUMNS)) begin
            put_col = '0;
            put_row = put_row + (ROW_W+1)'(1);
        end
        put_scroll  = 32'(put_row) >= 32'(ROWS);
        put_col_fin = put_col[COL_W-1:0];
        put_row_fin = put_scroll ? ROW_W'(ROWS - 1) : put_row[ROW_W-1:0];
    end

    // sequencer
    always_comb begin
        st_next        = st_reg;
        cnt_next       = cnt_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        act_next       = act_reg;
        code_next      = code_reg;
        cidx_next      = cidx_reg;
        scr_next       = scr_reg;
        rchar_next     = rchar_reg;
        rattr_next     = rattr_reg;
        opos_next      = opos_reg;
        ochar_next     = ochar_reg;
        oattr_next     = oattr_reg;
        oscr_next      = oscr_reg;
        out_valid_next = out_valid_reg;
        ram_we         = 1'b0;
        ram_waddr      = cnt_reg;
        ram_wdata      = '0;
        ram_raddr      = '0;

        if (m_tvalid && m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (st_reg)
            ST_INIT: begin
                // clearing pass after reset
                ram_we = 1'b1;
                if (cnt_reg == LAST_CELL) begin
                    cnt_next = '0;
                    st_next  = ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + ADDR_W'(1);
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    act_next  = s_tuser;
                    code_next = s_tdata[CHAR_W-1:0];
                    cidx_next = s_tdata[CHAR_W +: INDEX_W];
                    st_next   = ST_EXEC;
                end
            end
            ST_EXEC: begin
                scr_next   = 1'b0;
                rchar_next = '0;
                rattr_next = '0;
                unique case (act_reg)
                    ACT_PUT: begin
                        ram_we    = put_write;
                        ram_waddr = cur_addr;
                        ram_wdata = {attr_reg, code_reg};
                        col_next  = put_col_fin;
                        row_next  = put_row_fin;
                        scr_next  = put_scroll;
                        cnt_next  = '0;
                        st_next   = put_scroll ? ST_SCROLL : ST_DONE;
                    end
                    ACT_READ: begin
                        ram_raddr = ADDR_W'(cidx_reg);
                        st_next   = cidx_in_range ? ST_RDWAIT : ST_DONE;
                    end
                    ACT_CLEAR: begin
                        col_next = '0;
                        row_next = '0;
                        cnt_next = '0;
                        st_next  = ST_ZERO;
                    end
                    ACT_NONE: begin
                        st_next = ST_DONE;
                    end
                    default: begin
                        st_next = ST_DONE;
                    end
                endcase
            end
            ST_RDWAIT: begin
                rchar_next = ram_rdata[CHAR_W-1:0];
                rattr_next = ram_rdata[CELL_W-1:CHAR_W];
                st_next    = ST_DONE;
            end
            ST_SCROLL: begin
                // read one row below, write back the cell read last cycle
                if (cnt_reg != MOVE_END) begin
                    ram_raddr = cnt_reg + ROW_SPAN;
                end
                if (cnt_reg != '0) begin
                    ram_we    = 1'b1;
                    ram_waddr = cnt_reg - ADDR_W'(1);
                    ram_wdata = ram_rdata;
                end
                if (cnt_reg == MOVE_END) begin
                    st_next = ST_ZERO;
                end else begin
                    cnt_next = cnt_reg + ADDR_W'(1);
                end
            end
            ST_ZERO: begin
                ram_we = 1'b1;
                if (cnt_reg == LAST_CELL) begin
                    cnt_next = '0;
                    st_next  = ST_DONE;
                end else begin
                    cnt_next = cnt_reg + ADDR_W'(1);
                end
            end
            ST_DONE: begin
                opos_next      = INDEX_W'(cur_addr);
                ochar_next     = rchar_reg;
                oattr_next     = rattr_reg;
                oscr_next      = scr_reg;
                out_valid_next = 1'b1;
                st_next        = ST_IDLE;
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= ST_INIT;
            cnt_reg       <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            attr_reg      <= ATTR_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            st_reg        <= st_next;
            cnt_reg       <= cnt_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wen) begin
                attr_reg <= cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        act_reg   <= act_next;
        code_reg  <= code_next;
        cidx_reg  <= cidx_next;
        scr_reg   <= scr_next;
        rchar_reg <= rchar_next;
        rattr_reg <= rattr_next;
        opos_reg  <= opos_next;
        ochar_reg <= ochar_next;
        oattr_reg <= oattr_next;
        oscr_reg  <= oscr_next;
    end

endmodule

`default_nettype wire

FILE: test/text_console_cursor_engine_test.sv
`timescale 1ns / 1ps

module text_console_cursor_engine_test;
    import tcce_pkg::*;

    localparam int COLUMNS      = 80;
    localparam int ROWS         = 25;
    localparam int CELL_COUNT   = COLUMNS * ROWS;
    localparam int RANDOM_ITEMS = 425;
    localparam int PHASES       = 5;

    // laid out so that the low 28 bits of m_tdata map straight onto it
    typedef struct packed {
        logic               scrolled;
        logic [ATTR_W-1:0]  cell_attribute;
        logic [CHAR_W-1:0]  cell_char;
        logic [INDEX_W-1:0] cursor_position;
    } console_report_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_wen   = 1'b0;
    logic [ATTR_W-1:0]   cfg_wdata = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata   = '0;
    logic [ACTION_W-1:0] s_tuser   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    // shadow copy of the screen, cursor and attribute register
    logic [CELL_W-1:0] shadow_cells [CELL_COUNT];
    int                shadow_col  = 0;
    int                shadow_row  = 0;
    logic [ATTR_W-1:0] shadow_attr = ATTR_RESET;

    console_report_t expected_screen_reports [$];
    int              mismatch_count = 0;
    int              items_sent     = 0;

    // sender burst control
    bit          sender_gaps = 1'b1;
    int unsigned burst_left  = 0;

    text_console_cursor_engine #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #1 aclk = ~aclk;

    // apply one request to the shadow state and return the report it should give
    function automatic console_report_t console_apply(input logic [ACTION_W-1:0] action,
                                                      input logic [CHAR_W-1:0]   code,
                                                      input logic [INDEX_W-1:0]  index);
        console_report_t rep;
        int              i;
        rep = '0;
        case (action)
            ACT_PUT: begin
                if (code == CHR_BS) begin
                    if (shadow_col != 0) shadow_col--;
                end else if (code == CHR_TAB) begin
                    shadow_col = (shadow_col + TAB_STEP) & ~(TAB_STEP - 1);
                end else if (code == CHR_CR) begin
                    shadow_col = 0;
                end else if (code == CHR_LF) begin
                    shadow_col = 0;
                    shadow_row++;
                end else if (code >= CHR_SPACE) begin
                    shadow_cells[shadow_row * COLUMNS + shadow_col] = {shadow_attr, code};
                    shadow_col++;
                end
                // line end wraps, including a tab that lands past it
                if (shadow_col >= COLUMNS) begin
                    shadow_col = 0;
                    shadow_row++;
                end
                // past the last row: scroll up, blank bottom row
                if (shadow_row >= ROWS) begin
                    for (i = 0; i < CELL_COUNT - COLUMNS; i++)
                        shadow_cells[i] = shadow_cells[i + COLUMNS];
                    for (i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
                        shadow_cells[i] = '0;
                    shadow_row   = ROWS - 1;
                    rep.scrolled = 1'b1;
                end
            end
            ACT_READ: begin
                // beyond the store reads as a zero cell
                if (int'(index) < CELL_COUNT) begin
                    rep.cell_char      = shadow_cells[index][CHAR_W-1:0];
                    rep.cell_attribute = shadow_cells[index][CELL_W-1:CHAR_W];
                end
            end
            ACT_CLEAR: begin
                foreach (shadow_cells[k]) shadow_cells[k] = '0;
                shadow_col = 0;
                shadow_row = 0;
            end
            default: ;
        endcase
        rep.cursor_position = INDEX_W'(shadow_row * COLUMNS + shadow_col);
        return rep;
    endfunction

    // drive one request at the falling edge, wait for the handshake, record the prediction
    task automatic send_request(input logic [ACTION_W-1:0] action,
                                input logic [CHAR_W-1:0]   code,
                                input logic [INDEX_W-1:0]  index);
        int unsigned gap;
        gap = 0;
        if (sender_gaps) begin
            if (burst_left == 0) begin
                gap        = $urandom_range(1, 12);
                burst_left = $urandom_range(1, 16);
            end else begin
                burst_left--;
            end
        end
        @(negedge aclk);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= action;
        s_tdata  <= S_DATA_W'({index, code});
        do @(posedge aclk); while (!s_tready);
        expected_screen_reports.push_back(console_apply(action, code, index));
        items_sent++;
    endtask

    // unused fields get random content so every bit toggles
    task automatic put_char(input logic [CHAR_W-1:0] code);
        send_request(ACT_PUT, code, INDEX_W'($urandom_range(0, 2**INDEX_W - 1)));
    endtask

    task automatic read_cell(input logic [INDEX_W-1:0] index);
        send_request(ACT_READ, CHAR_W'($urandom_range(0, 255)), index);
    endtask

    task automatic clear_screen();
        send_request(ACT_CLEAR, CHAR_W'($urandom_range(0, 255)),
                     INDEX_W'($urandom_range(0, 2**INDEX_W - 1)));
    endtask

    // sender goes quiet until every outstanding report has come back
    task automatic pause_until_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_screen_reports.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // only called with nothing in flight
    task automatic write_attribute(input logic [ATTR_W-1:0] value);
        @(negedge aclk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wen   <= 1'b0;
        shadow_attr = value;
    endtask

    // freshly cleared store, cursor home, unused action
    task automatic test_reset_state();
        read_cell(INDEX_W'(0));
        read_cell(INDEX_W'(CELL_COUNT - 1));
        send_request(ACT_NONE, 8'hFF, 11'h7FF);
    endtask

    // each control code, ignored codes, printable extremes, reads past the store
    task automatic test_control_codes();
        put_char(CHR_BS);            // backspace at column 0 stays put
        put_char(8'h41);             // written with the reset attribute
        read_cell(INDEX_W'(0));
        put_char(8'h00);             // ignored control codes
        put_char(8'h1F);
        put_char(8'hFF);
        put_char(CHR_BS);
        put_char(CHR_CR);
        put_char(CHR_TAB);
        put_char(CHR_LF);
        put_char(CHR_SPACE);
        read_cell(INDEX_W'(CELL_COUNT));
        read_cell(11'h7FF);
    endtask

    task automatic test_clear_screen();
        clear_screen();
        read_cell(INDEX_W'(0));
        read_cell(INDEX_W'(1));
    endtask

    task automatic test_attribute_extremes();
        pause_until_drained();
        write_attribute(8'h00);
        put_char(8'h7E);
        read_cell(INDEX_W'(0));
        pause_until_drained();
        write_attribute(8'hFF);
        put_char(8'h80);
        read_cell(INDEX_W'(1));
    endtask

    // mostly text lines and line feed runs so the cursor reaches the bottom and scrolls
    task automatic test_random_traffic();
        logic [ATTR_W-1:0]  attr;
        logic [INDEX_W-1:0] index;
        int                 phase;
        int                 phase_end;
        int                 pick;
        int                 n;
        int                 k;
        int                 near;
        for (phase = 0; phase < PHASES; phase++) begin
            pause_until_drained();
            case (phase)
                0:       attr = 8'h00;
                1:       attr = 8'hFF;
                default: attr = ATTR_W'($urandom_range(0, 255));
            endcase
            write_attribute(attr);
            // first phase runs with no sender gaps
            sender_gaps = (phase != 0);
            phase_end   = items_sent + RANDOM_ITEMS / PHASES;
            while (items_sent < phase_end) begin
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    // text line, now and then long enough to wrap
                    n = ($urandom_range(0, 6) == 0) ? $urandom_range(60, 100)
                                                    : $urandom_range(0, 30);
                    for (k = 0; k < n; k++) begin
                        pick = $urandom_range(0, 99);
                        if (pick < 8)
                            put_char(CHR_TAB);
                        else if (pick < 12)
                            put_char(CHR_BS);
                        else if (pick < 14)
                            put_char(CHAR_W'($urandom_range(0, CHR_SPACE - 1)));
                        else
                            put_char(CHAR_W'($urandom_range(CHR_SPACE, 255)));
                    end
                    pick = $urandom_range(0, 99);
                    if (pick < 70) begin
                        put_char(CHR_LF);
                    end else if (pick < 85) begin
                        put_char(CHR_CR);
                        put_char(CHR_LF);
                    end
                end else if (pick < 70) begin
                    repeat ($urandom_range(1, 30)) put_char(CHR_LF);
                end else if (pick < 85) begin
                    repeat ($urandom_range(1, 6)) begin
                        // near the cursor, anywhere on screen, or anywhere in the index range
                        near = shadow_row * COLUMNS + shadow_col
                               - int'($urandom_range(1, 2 * COLUMNS));
                        case ($urandom_range(0, 4))
                            0, 1:    index = INDEX_W'((near < 0) ? 0 : near);
                            2, 3:    index = INDEX_W'($urandom_range(0, CELL_COUNT - 1));
                            default: index = INDEX_W'($urandom_range(0, 2**INDEX_W - 1));
                        endcase
                        read_cell(index);
                    end
                end else if (pick < 95) begin
                    // noise: arbitrary bytes and the unused action
                    repeat ($urandom_range(1, 4)) begin
                        if ($urandom_range(0, 1) == 0)
                            put_char(CHAR_W'($urandom_range(0, 255)));
                        else
                            send_request(ACT_NONE, CHAR_W'($urandom_range(0, 255)),
                                         INDEX_W'($urandom_range(0, 2**INDEX_W - 1)));
                    end
                end else if (pick < 97) begin
                    clear_screen();
                end else begin
                    pause_until_drained();
                end
            end
        end
    endtask

    // receiver stall pattern, switching style as bits [9:8] of rx_cycle change
    bit [31:0]   rx_cycle   = 0;
    int unsigned stall_left = 0;

    always @(negedge aclk) begin
        rx_cycle = rx_cycle + 1;
        case (rx_cycle[9:8])
            2'd0: m_tready <= 1'b1;
            2'd1: m_tready <= ($urandom_range(0, 3) != 0);
            2'd2: begin
                if (stall_left != 0) begin
                    stall_left--;
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                    if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 24);
                end
            end
            default: m_tready <= rx_cycle[0];
        endcase
    end

    // compare every accepted report with the oldest prediction
    always @(posedge aclk) begin : report_check
        console_report_t want;
        console_report_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[$bits(console_report_t)-1:0];
            if (expected_screen_reports.size() == 0) begin
                $error("unexpected report, cursor_position %0d", got.cursor_position);
                mismatch_count++;
            end else begin
                want = expected_screen_reports.pop_front();
                if (got.cursor_position !== want.cursor_position) begin
                    $error("cursor_position: expected %0d, actual %0d",
                           want.cursor_position, got.cursor_position);
                    mismatch_count++;
                end
                if (got.cell_char !== want.cell_char) begin
                    $error("cell_char: expected 0x%02h, actual 0x%02h",
                           want.cell_char, got.cell_char);
                    mismatch_count++;
                end
                if (got.cell_attribute !== want.cell_attribute) begin
                    $error("cell_attribute: expected 0x%02h, actual 0x%02h",
                           want.cell_attribute, got.cell_attribute);
                    mismatch_count++;
                end
                if (got.scrolled !== want.scrolled) begin
                    $error("scrolled: expected %0d, actual %0d", want.scrolled, got.scrolled);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        foreach (shadow_cells[i]) shadow_cells[i] = '0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_state();
        test_control_codes();
        test_clear_screen();
        test_attribute_extremes();
        test_random_traffic();

        // let the last reports come home, then a short tail for strays
        pause_until_drained();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // hang guard, well beyond the slowest legal run
    initial begin
        #20000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: text_console_cursor_engine.f
rtl/tcce_pkg.sv
rtl/tcce_ram.sv
rtl/text_console_cursor_engine.sv
test/text_console_cursor_engine_test.sv
